// ----- rtl/prc_pkg.sv -----
package prc_pkg;

    // field and counter widths
    localparam int CFG_W       = 13;
    localparam int REG_IDX_W   = 3;
    localparam int BYTE_W      = 8;
    localparam int ROW_BYTES_W = 15;
    localparam int ROW_W       = 13;
    localparam int PAD_W       = 2;

    // default image size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CROP_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CROP_HEIGHT   = 3'd3;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_POSITIVE = 2'd1,
        ST_TOO_LARGE    = 2'd2
    } status_t;

    // geometry derived from the registers
    typedef struct packed {
        status_t                  status;
        logic [ROW_BYTES_W-1:0]   row_last_byte;
        logic [ROW_BYTES_W-1:0]   kept_last_byte;
        logic [PAD_W-1:0]         pad_count;
        logic [ROW_W-1:0]         first_row;
        logic [ROW_W-1:0]         last_row;
    } geom_t;

    // one result word plus the padding still owed after it
    typedef struct packed {
        logic [BYTE_W-1:0]        data;
        logic                     last_row_end;
        logic [PAD_W-1:0]         pad_left;
        status_t                  status;
    } word_t;

endpackage

// ----- rtl/prc_cfg.sv -----
module prc_cfg #(
    parameter int MAX_WIDTH  = prc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = prc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [prc_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [prc_pkg::CFG_W-1:0]      cfg_wdata,
    output logic                           cnt_clear,
    output prc_pkg::geom_t                 geom
);
    import prc_pkg::*;

    logic [CFG_W-1:0]       src_w_reg, src_h_reg, crop_w_reg, crop_h_reg;
    logic [CFG_W-1:0]       src_w_next, src_h_next, crop_w_next, crop_h_next;
    geom_t                  geom_reg, geom_next;
    logic [CFG_W-1:0]       sw_c, sh_c;
    logic [ROW_BYTES_W-1:0] row_sum, row_bytes, kept;

    // register writes
    always_comb begin
        src_w_next  = src_w_reg;
        src_h_next  = src_h_reg;
        crop_w_next = crop_w_reg;
        crop_h_next = crop_h_reg;
        cnt_clear   = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SOURCE_WIDTH: begin
                    src_w_next = cfg_wdata;
                    cnt_clear  = 1'b1;
                end
                REG_SOURCE_HEIGHT: begin
                    src_h_next = cfg_wdata;
                    cnt_clear  = 1'b1;
                end
                REG_CROP_WIDTH: begin
                    crop_w_next = cfg_wdata;
                    cnt_clear   = 1'b1;
                end
                REG_CROP_HEIGHT: begin
                    crop_h_next = cfg_wdata;
                    cnt_clear   = 1'b1;
                end
                default: begin
                    cnt_clear = 1'b0;
                end
            endcase
        end
    end

    // clamp source size and derive row geometry
    always_comb begin
        sw_c = (32'(src_w_reg) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : src_w_reg;
        sh_c = (32'(src_h_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : src_h_reg;
        row_sum   = {1'b0, sw_c, 1'b0} + {2'b00, sw_c} + ROW_BYTES_W'(3);
        row_bytes = {row_sum[ROW_BYTES_W-1:2], 2'b00};
        kept      = {1'b0, crop_w_reg, 1'b0} + {2'b00, crop_w_reg};

        geom_next.row_last_byte  = row_bytes - ROW_BYTES_W'(1);
        geom_next.kept_last_byte = kept - ROW_BYTES_W'(1);
        geom_next.pad_count      = 2'd0 - kept[1:0];
        geom_next.first_row      = sh_c - crop_h_reg;
        geom_next.last_row       = sh_c - ROW_W'(1);

        if (crop_w_reg == '0 || crop_h_reg == '0) begin
            geom_next.status = ST_NOT_POSITIVE;
        end else if (crop_w_reg > sw_c || crop_h_reg > sh_c) begin
            geom_next.status = ST_TOO_LARGE;
        end else begin
            geom_next.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg  <= CFG_W'(1);
            src_h_reg  <= CFG_W'(1);
            crop_w_reg <= CFG_W'(1);
            crop_h_reg <= CFG_W'(1);
        end else begin
            src_w_reg  <= src_w_next;
            src_h_reg  <= src_h_next;
            crop_w_reg <= crop_w_next;
            crop_h_reg <= crop_h_next;
        end
    end

    // derived geometry, registered from the configuration registers
    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

// ----- rtl/prc_front.sv -----
module prc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prc_pkg::BYTE_W-1:0]    s_source_byte,
    input  prc_pkg::geom_t                geom,
    input  logic                          cnt_clear,
    input  logic                          out_free,
    output logic                          job_load,
    output prc_pkg::word_t                job
);
    import prc_pkg::*;

    logic                   a_valid_reg, a_valid_next;
    logic [BYTE_W-1:0]      a_byte_reg;
    logic [ROW_BYTES_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic                   keep, row_end, emit, a_go;

    // decide what the held byte gives
    always_comb begin
        row_end = (col_reg == geom.kept_last_byte);
        keep    = (row_reg >= geom.first_row) && (col_reg <= geom.kept_last_byte);
        if (geom.status != ST_OK) begin
            emit             = 1'b1;
            job.data         = '0;
            job.last_row_end = 1'b0;
            job.pad_left     = '0;
        end else begin
            emit             = keep;
            job.data         = a_byte_reg;
            job.last_row_end = row_end && (row_reg == geom.last_row);
            job.pad_left     = row_end ? geom.pad_count : '0;
        end
        job.status = geom.status;
        a_go       = a_valid_reg && (!emit || out_free);
        job_load   = a_go && emit;
        s_ready    = !a_valid_reg || a_go;
    end

    // source position counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cnt_clear) begin
            col_next = '0;
            row_next = '0;
        end else if (a_go && geom.status == ST_OK) begin
            if (col_reg >= geom.row_last_byte) begin
                col_next = '0;
                row_next = (row_reg >= geom.last_row) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + ROW_BYTES_W'(1);
            end
        end
    end

    assign a_valid_next = s_ready ? s_valid : a_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_byte_reg <= s_source_byte;
        end
    end

endmodule

// ----- rtl/prc_out.sv -----
module prc_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_load,
    input  prc_pkg::word_t                job,
    output logic                          out_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prc_pkg::BYTE_W-1:0]    m_result_byte,
    output logic                          m_end_of_image,
    output logic [1:0]                    m_status
);
    import prc_pkg::*;

    logic  b_valid_reg, b_valid_next;
    word_t word_reg, word_next;

    assign out_free = !b_valid_reg || (m_ready && word_reg.pad_left == '0);

    // result register: data word, then zero padding words
    always_comb begin
        b_valid_next = b_valid_reg;
        word_next    = word_reg;
        if (job_load) begin
            b_valid_next = 1'b1;
            word_next    = job;
        end else if (b_valid_reg && m_ready) begin
            if (word_reg.pad_left == '0) begin
                b_valid_next = 1'b0;
            end else begin
                word_next.data     = '0;
                word_next.pad_left = word_reg.pad_left - PAD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign m_valid        = b_valid_reg;
    assign m_result_byte  = word_reg.data;
    assign m_end_of_image = word_reg.last_row_end && (word_reg.pad_left == '0);
    assign m_status       = word_reg.status;

endmodule

// ----- rtl/padded_rgb_row_crop_top.sv -----
// Streaming crop of a bottom-up 24-bit image: takes one padded source byte
// per cycle while s_ready is high and passes the top crop_height rows, each
// cut to crop_width pixels and re-padded with zero bytes to a multiple of
// four; with invalid registers each byte gives a zero word and the error
// status. A kept byte waits in the input register while the result register
// still sends a word or its padding bytes (0 to 3); the result register
// sends one word per cycle while m_ready is high. Register writes reach the
// geometry through its register and restart the image at the first byte.
module padded_rgb_row_crop_top #(
    parameter int MAX_WIDTH  = prc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = prc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [prc_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [prc_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [prc_pkg::BYTE_W-1:0]     s_source_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [prc_pkg::BYTE_W-1:0]     m_result_byte,
    output logic                           m_end_of_image,
    output logic [1:0]                     m_status
);
    import prc_pkg::*;

    geom_t geom;
    word_t job;
    logic  cnt_clear, out_free, job_load;

    // registers and derived geometry
    prc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cnt_clear (cnt_clear),
        .geom      (geom)
    );

    // input register, position counters and keep decision
    prc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_byte (s_source_byte),
        .geom          (geom),
        .cnt_clear     (cnt_clear),
        .out_free      (out_free),
        .job_load      (job_load),
        .job           (job)
    );

    // result register with padding
    prc_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_load       (job_load),
        .job            (job),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_byte  (m_result_byte),
        .m_end_of_image (m_end_of_image),
        .m_status       (m_status)
    );

`ifndef SYNTHESIS
    // end of image only on good words
    a_eoi_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_image |-> m_status == ST_OK)
        else $error("end of image flagged on an error word");

    // error words carry a zero byte
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_result_byte == '0)
        else $error("error word with non-zero byte");

    // a fresh word enters the result register only when it was free
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load |-> out_free)
        else $error("result register overwritten");
`endif

endmodule
